/* sv/pal_pkg.sv */
// Package for the priority-aware LRU replacement block.
// Holds sizes, field widths, row layout and the item kind codes.
// No dependencies.
package pal_pkg;

    localparam int CORES = 4;
    localparam int SETS  = 1024;
    localparam int WAYS  = 16;

    // Fixed field widths of the word formats
    localparam int KIND_W = 2;
    localparam int CORE_W = 2;
    localparam int SET_W  = 10;
    localparam int WAY_W  = 4;
    localparam int THR_W  = 5;

    // Derived storage widths
    localparam int CORE_IX_W = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int ADDR_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RANK_W    = $clog2(WAYS);
    localparam int CNT_W     = $clog2(WAYS + 1);
    localparam int SLICE_W   = WAYS + WAYS * RANK_W;
    localparam int ROW_W     = CORES * SLICE_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_INIT   = 2'd0;
    localparam kind_t KIND_UPDATE = 2'd1;
    localparam kind_t KIND_VICTIM = 2'd2;

    // One core's replacement state for one set
    typedef struct packed {
        logic [WAYS-1:0][RANK_W-1:0] rank;
        logic [WAYS-1:0]             prio;
    } slice_t;

    // One memory row: every core's state for one set
    typedef slice_t [CORES-1:0] row_t;

    function automatic row_t reset_row();
        row_t row;
        for (int c = 0; c < CORES; c++)
        begin
            row[c].prio = '0;
            for (int w = 0; w < WAYS; w++)
            begin
                row[c].rank[w] = RANK_W'(w);
            end
        end
        return row;
    endfunction

endpackage

/* sv/pal_req_if.sv */
// Request channel of the replacement block: valid/ready plus item fields.
// Depends on pal_pkg for field widths.
interface pal_req_if;
    import pal_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CORE_W-1:0] core_id;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way;
    logic              high_priority;

    modport source (
        output valid, kind, core_id, set_index, way, high_priority,
        input  ready
    );

    modport sink (
        input  valid, kind, core_id, set_index, way, high_priority,
        output ready
    );
endinterface

/* sv/pal_rsp_if.sv */
// Response channel of the replacement block: valid/ready plus victim fields.
// Depends on pal_pkg for field widths.
interface pal_rsp_if;
    import pal_pkg::*;

    logic             valid;
    logic             ready;
    logic [WAY_W-1:0] victim_way;
    logic             evict_high_group;
    logic             group_found;

    modport source (
        output valid, victim_way, evict_high_group, group_found,
        input  ready
    );

    modport sink (
        input  valid, victim_way, evict_high_group, group_found,
        output ready
    );
endinterface

/* sv/pal_ram.sv */
// Generic simple dual-port RAM, one write and one read port, registered read.
// No package dependency.
module pal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* sv/priority_aware_lru_replacement.sv */
// Priority-aware LRU replacement state, one memory row per set for all cores.
// Depends on pal_pkg, pal_req_if, pal_rsp_if and pal_ram.
//
//  channel   dir  handshake     word contents
//  req       in   valid/ready   kind, core_id, set_index, way, high_priority
//  rsp       out  valid/ready   victim_way, evict_high_group, group_found
//  cfg       in   cfg_wen       cfg_wdata -> eviction threshold
//
// Steps: init writes the reset row on acceptance; update reads, then modifies and
//   writes back the row; victim reads, counts and latches the core's slice, then
//   picks the oldest way; undefined kinds are accepted and have no effect.
// Reset: a clearing pass writes the reset row to each of the SETS rows,
//   with req.ready low; cfg writes are taken throughout.
// Stalls: a victim word waits in the output register; the block holds in its
//   pick step only while that register is still full and rsp.ready is low.
module priority_aware_lru_replacement (
    input  logic                     clk,
    input  logic                     rst_n,
    pal_req_if.sink                  req,
    pal_rsp_if.source                rsp,
    input  logic                     cfg_wen,
    input  logic [pal_pkg::THR_W-1:0] cfg_wdata
);
    import pal_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CALC  = 4'b0100,
        S_PICK  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]  thr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // item held across the read-modify-write
    kind_t                kind_reg;
    logic [CORE_IX_W-1:0] core_reg;
    logic [ADDR_W-1:0]    set_reg;
    logic [RANK_W-1:0]    way_reg;
    logic                 hp_reg;
    logic                 skip_reg;

    // victim pick stage
    slice_t pick_slice_reg;
    logic   high_reg;

    // output register
    logic             rsp_valid_reg;
    logic [WAY_W-1:0] victim_reg;
    logic             high_out_reg;
    logic             found_reg;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    row_t              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    row_t              ram_rdata;

    logic acc;
    logic set_ok, core_ok, way_ok, skip_in;
    logic rsp_load;

    row_t              upd_row;
    slice_t            upd_slice;
    slice_t            sel_slice;
    logic [CNT_W-1:0]  hp_count;

    logic [WAYS-1:0]   cand;
    logic [WAYS-1:0]   occ;
    logic [RANK_W-1:0] best_rank;
    logic [RANK_W-1:0] victim_ix;
    logic              found;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;

    // range checks; all pass at the default sizes
    assign set_ok  = (int'(req.set_index) < SETS);
    assign core_ok = (int'(req.core_id) < CORES);
    assign way_ok  = (int'(req.way) < WAYS);
    assign skip_in = !(set_ok && core_ok && ((req.kind != KIND_UPDATE) || way_ok));

    assign ram_re    = acc;
    assign ram_raddr = req.set_index[ADDR_W-1:0];

    pal_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // update: age ways younger than the old rank, make the way MRU
    always_comb
    begin
        logic [RANK_W-1:0] old_rank;
        upd_row   = ram_rdata;
        upd_slice = ram_rdata[core_reg];
        old_rank  = upd_slice.rank[way_reg];
        for (int w = 0; w < WAYS; w++)
        begin
            if (upd_slice.rank[w] < old_rank)
            begin
                upd_slice.rank[w] = upd_slice.rank[w] + RANK_W'(1);
            end
        end
        upd_slice.rank[way_reg] = '0;
        upd_slice.prio[way_reg] = hp_reg;
        upd_row[core_reg]       = upd_slice;
    end

    // victim, first step: select core, count high-priority ways
    always_comb
    begin
        sel_slice = ram_rdata[core_reg];
        hp_count  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hp_count = hp_count + CNT_W'(sel_slice.prio[w]);
        end
    end

    // victim, second step: mark occupied ranks of the chosen group,
    // take the highest, then the lowest way holding it
    always_comb
    begin
        occ       = '0;
        best_rank = '0;
        victim_ix = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            cand[w] = (pick_slice_reg.prio[w] == high_reg);
        end
        for (int r = 0; r < WAYS; r++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (cand[w] && (pick_slice_reg.rank[w] == RANK_W'(r)))
                begin
                    occ[r] = 1'b1;
                end
            end
        end
        for (int r = 0; r < WAYS; r++)
        begin
            if (occ[r])
            begin
                best_rank = RANK_W'(r);
            end
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (cand[w] && (pick_slice_reg.rank[w] == best_rank))
            begin
                victim_ix = RANK_W'(w);
            end
        end
        found = |cand;
    end

    assign rsp_load = (state_reg == S_PICK) && (!rsp_valid_reg || rsp.ready);

    // write port: clearing pass, init rows, update write-back
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = reset_row();
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                ram_waddr = req.set_index[ADDR_W-1:0];
                ram_we    = acc && (req.kind == KIND_INIT) && set_ok;
            end
            S_CALC:
            begin
                ram_waddr = set_reg;
                ram_wdata = upd_row;
                ram_we    = (kind_reg == KIND_UPDATE) && !skip_reg;
            end
            S_PICK:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc && ((req.kind == KIND_UPDATE) || (req.kind == KIND_VICTIM)))
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = (kind_reg == KIND_VICTIM) ? S_PICK : S_IDLE;
            end
            S_PICK:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            thr_reg       <= THR_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_wen)
            begin
                thr_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            kind_reg <= req.kind;
            core_reg <= req.core_id[CORE_IX_W-1:0];
            set_reg  <= req.set_index[ADDR_W-1:0];
            way_reg  <= req.way[RANK_W-1:0];
            hp_reg   <= req.high_priority;
            skip_reg <= skip_in;
        end
        if (state_reg == S_CALC)
        begin
            pick_slice_reg <= sel_slice;
            high_reg       <= (CNT_W'(thr_reg) < hp_count);
        end
        if (rsp_load)
        begin
            victim_reg   <= skip_reg ? '0 : WAY_W'(victim_ix);
            high_out_reg <= skip_reg ? 1'b0 : high_reg;
            found_reg    <= skip_reg ? 1'b0 : found;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.victim_way       = victim_reg;
    assign rsp.evict_high_group = high_out_reg;
    assign rsp.group_found      = found_reg;

endmodule

/* sv/pal_checker.sv */
// Port-level checks for the replacement block, bound to the top level.
// Depends on pal_pkg and priority_aware_lru_replacement.
module pal_port_checks (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic [pal_pkg::KIND_W-1:0] req_kind,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [pal_pkg::WAY_W-1:0] rsp_victim_way,
    input logic                     rsp_evict_high_group,
    input logic                     rsp_group_found
);
    import pal_pkg::*;

    // a waiting word holds still
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_victim_way)
            && $stable(rsp_evict_high_group) && $stable(rsp_group_found))
        else $error("rsp word changed while stalled");

    // empty group defaults to way 0
    a_empty_way0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_group_found |-> rsp_victim_way == '0)
        else $error("victim way not 0 for empty group");

    // read-modify-write kinds drop req.ready in the cycle after acceptance
    a_rmw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_kind == KIND_UPDATE || req_kind == KIND_VICTIM)
            |=> !req_ready)
        else $error("req accepted during read-modify-write");

    // victim word appears after the calc and pick states when the output is free
    a_victim_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_kind == KIND_VICTIM && !rsp_valid |-> ##3 rsp_valid)
        else $error("victim word late");
endmodule

bind priority_aware_lru_replacement pal_port_checks u_pal_port_checks (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .req_kind             (req.kind),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_victim_way       (rsp.victim_way),
    .rsp_evict_high_group (rsp.evict_high_group),
    .rsp_group_found      (rsp.group_found)
);
